FILE: hdl/trpd_pkg.sv
package trpd_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_PRESENT     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_PIXEL_COUNT = 1'd1;

    localparam int PIXEL_COUNT_W = 24;
    localparam int OUT_INDEX_W   = 24;

    localparam logic [7:0] RUN_FLAG_MASK = 8'h80;
    localparam logic [7:0] COUNT_MASK    = 8'h7f;
    localparam logic [7:0] ALPHA_OPAQUE  = 8'd255;

    // pixel handed from front to back
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       restart;      // image_start seen since previous pixel
    } trpd_pixel_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } trpd_q_status_t;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

endpackage

FILE: hdl/tga_rle_pixel_decoder.sv
// RLE truecolor TGA pixel decoder.
// s_ channel: one pixel-data byte per transfer. s_tdata = stream_byte,
//   s_tuser = image_start (clears pixel index and packet state first).
// m_ channel: one transfer per completed pixel. m_tdata carries color,
//   start index and repeat count; m_tuser = past_end.
// cfg port: cfg_we/cfg_index/cfg_data, index 0 alpha_present,
//   index 1 image_pixel_count. Write only while the block is idle.
// Throughput: one byte per cycle while the queue has room; a pixel result every 3 or 4
//   bytes, plus one byte per packet header.
// Path: the byte that completes a pixel writes a queue entry at its
//   transfer; the back then loads the output register from that entry,
//   which raises m_tvalid.
// The front decodes packets; the back keeps the running pixel index
//   (one add and compare per pixel) and owns the output register.
// Reset (aresetn low, synchronous): expect packet header, index 0,
//   queue and output empty, alpha_present 0, image_pixel_count 2^24-1.
// Receiver stall: the output register holds; the queue absorbs up to
//   two pixels, after which s_tready drops until m_tready returns.
module tga_rle_pixel_decoder #(
    parameter int INDEX_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] stream_byte
    input  logic                                s_tuser,   // [0] image_start
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
    // [55:32] pixel_index, [63:56] repeat_count
    output logic [63:0]                         m_tdata,
    output logic                                m_tuser,   // [0] past_end
    input  logic                                cfg_we,
    input  logic [trpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [trpd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import trpd_pkg::*;

    logic                     alpha_present_reg;
    logic [PIXEL_COUNT_W-1:0] image_pixel_count_reg;

    logic           byte_xfer;
    logic           push;
    logic           pop;
    trpd_pixel_t    push_item;
    trpd_pixel_t    pop_item;
    trpd_q_status_t q_status;

    // front only needs room for a pixel it may produce this cycle
    assign s_tready  = !q_status.full;
    assign byte_xfer = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_present_reg     <= 1'b0;
            image_pixel_count_reg <= '1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ALPHA_PRESENT:     alpha_present_reg     <= cfg_data[0];
                CFG_IMAGE_PIXEL_COUNT: image_pixel_count_reg <= cfg_data[PIXEL_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    trpd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .byte_valid    (byte_xfer),
        .stream_byte   (s_tdata),
        .image_start   (s_tuser),
        .alpha_present (alpha_present_reg),
        .push          (push),
        .push_item     (push_item)
    );

    trpd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    trpd_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_status          (q_status),
        .q_item            (pop_item),
        .pop               (pop),
        .image_pixel_count (image_pixel_count_reg),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_data          (m_tdata),
        .out_past_end      (m_tuser)
    );

endmodule

FILE: hdl/trpd_front.sv
module trpd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_valid,
    input  logic [7:0]           stream_byte,
    input  logic                 image_start,
    input  logic                 alpha_present,
    output logic                 push,
    output trpd_pkg::trpd_pixel_t push_item
);
    import trpd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_BLUE,
        PH_GREEN,
        PH_RED,
        PH_ALPHA
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        run_reg, run_next;
    logic [7:0]  count_reg, count_next;
    logic        restart_reg, restart_next;
    logic [7:0]  blue_reg, blue_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  red_reg, red_next;

    phase_t      phase_eff;
    logic        run_eff;
    logic [7:0]  count_eff;
    logic        restart_eff;
    logic        emit;
    logic [7:0]  emit_red;
    logic [7:0]  emit_alpha;

    always_comb begin
        phase_eff   = image_start ? PH_HEADER : phase_reg;
        run_eff     = image_start ? 1'b0 : run_reg;
        count_eff   = image_start ? 8'd0 : count_reg;
        restart_eff = restart_reg | image_start;

        phase_next   = phase_eff;
        run_next     = run_eff;
        count_next   = count_eff;
        restart_next = restart_eff;
        blue_next    = blue_reg;
        green_next   = green_reg;
        red_next     = red_reg;
        emit         = 1'b0;
        emit_red     = red_reg;
        emit_alpha   = ALPHA_OPAQUE;

        unique case (phase_eff)
            PH_HEADER: begin
                run_next   = (stream_byte & RUN_FLAG_MASK) != 8'd0;
                count_next = (stream_byte & COUNT_MASK) + 8'd1;
                phase_next = PH_BLUE;
            end
            PH_BLUE: begin
                blue_next  = stream_byte;
                phase_next = PH_GREEN;
            end
            PH_GREEN: begin
                green_next = stream_byte;
                phase_next = PH_RED;
            end
            PH_RED: begin
                red_next = stream_byte;
                emit_red = stream_byte;
                if (alpha_present) begin
                    phase_next = PH_ALPHA;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_ALPHA: begin
                emit       = 1'b1;
                emit_alpha = stream_byte;
            end
            default: phase_next = PH_HEADER;
        endcase

        if (emit) begin
            restart_next = 1'b0;
            if (run_eff) begin
                count_next = 8'd0;
                phase_next = PH_HEADER;
            end else begin
                count_next = count_eff - 8'd1;
                phase_next = (count_next == 8'd0) ? PH_HEADER : PH_BLUE;
            end
        end

        push_item.red          = emit_red;
        push_item.green        = green_reg;
        push_item.blue         = blue_reg;
        push_item.alpha        = emit_alpha;
        push_item.repeat_count = run_eff ? count_eff : 8'd1;
        push_item.restart      = restart_eff;
        push = byte_valid & emit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            run_reg     <= 1'b0;
            count_reg   <= 8'd0;
            restart_reg <= 1'b0;
        end else if (byte_valid) begin
            phase_reg   <= phase_next;
            run_reg     <= run_next;
            count_reg   <= count_next;
            restart_reg <= restart_next;
        end
    end

    // color holds are payload, written before any read
    always_ff @(posedge aclk) begin
        if (byte_valid) begin
            blue_reg  <= blue_next;
            green_reg <= green_next;
            red_reg   <= red_next;
        end
    end

endmodule

FILE: hdl/trpd_queue.sv
module trpd_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  trpd_pkg::trpd_pixel_t    push_item,
    input  logic                     pop,
    output trpd_pkg::trpd_pixel_t    pop_item,
    output trpd_pkg::trpd_q_status_t status
);
    import trpd_pkg::*;

    trpd_pixel_t          mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   fill_reg, fill_next;
    logic                 do_push, do_pop;

    always_comb begin
        do_push      = push & (fill_reg != Q_CNT_W'(Q_DEPTH));
        do_pop       = pop & (fill_reg != '0);
        wr_ptr_next  = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next  = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next    = fill_reg + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
        status.full  = fill_reg == Q_CNT_W'(Q_DEPTH);
        status.empty = fill_reg == '0;
        pop_item     = mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hdl/trpd_back.sv
module trpd_back #(
    parameter int INDEX_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  trpd_pkg::trpd_q_status_t             q_status,
    input  trpd_pkg::trpd_pixel_t                q_item,
    output logic                                 pop,
    input  logic [trpd_pkg::PIXEL_COUNT_W-1:0]   image_pixel_count,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [63:0]                          out_data,
    output logic                                 out_past_end
);
    import trpd_pkg::*;

    // compare width covers both the index sum and the pixel count
    localparam int SUM_W = INDEX_BITS + 1;
    localparam int CMP_W = (SUM_W > PIXEL_COUNT_W + 1) ? SUM_W : PIXEL_COUNT_W + 1;

    logic [INDEX_BITS-1:0] next_pixel_reg, next_pixel_next;
    logic                  valid_reg, valid_next;
    logic [63:0]           data_reg, data_next;
    logic                  past_end_reg, past_end_next;

    logic [INDEX_BITS-1:0] start;
    logic [SUM_W-1:0]      sum;
    logic [CMP_W-1:0]      start_ext;

    always_comb begin
        pop       = !q_status.empty && (!valid_reg || out_ready);
        start     = q_item.restart ? '0 : next_pixel_reg;
        sum       = SUM_W'(start) + SUM_W'(q_item.repeat_count);
        start_ext = CMP_W'(start);

        next_pixel_next = next_pixel_reg;
        valid_next      = valid_reg;
        data_next       = data_reg;
        past_end_next   = past_end_reg;

        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end
        if (pop) begin
            valid_next      = 1'b1;
            // saturate instead of wrapping past the top index
            next_pixel_next = sum[INDEX_BITS] ? '1 : sum[INDEX_BITS-1:0];
            data_next       = {q_item.repeat_count, start_ext[OUT_INDEX_W-1:0],
                               q_item.alpha, q_item.blue, q_item.green, q_item.red};
            past_end_next   = CMP_W'(sum) > CMP_W'(image_pixel_count);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_pixel_reg <= '0;
            valid_reg      <= 1'b0;
        end else begin
            next_pixel_reg <= next_pixel_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg     <= data_next;
        past_end_reg <= past_end_next;
    end

    assign out_valid    = valid_reg;
    assign out_data     = data_reg;
    assign out_past_end = past_end_reg;

endmodule

FILE: hdl/trpd_checker.sv
module trpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser,
    input logic        cfg_we,
    input logic [0:0]  cfg_index,
    input logic [23:0] cfg_data
);

    // output empties on reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // repeat count is 1..128
    a_repeat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[63:56] != 8'd0 && m_tdata[63:56] <= 8'd128)
        else $error("repeat_count out of range");

    // a result can only follow an input byte transfer
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2) || $past(!m_tready || !m_tvalid))
        else $error("result without input");

endmodule

bind tga_rle_pixel_decoder trpd_checker u_trpd_checker (.*);

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import trpd_pkg::*;

    // Idle cycles with no transfer on either channel before the run is declared hung.
    // This leaves room for the longest receiver hold-off plus random gaps.
    localparam int HANG_LIMIT = 2000;
    localparam logic [23:0] INDEX_MAX = 24'hFFFFFF;
    // Results pass through the queue and the output register; settle this long before config writes.
    localparam int SETTLE_CYCLES = 8;

    // Decoder byte position within a packet
    typedef enum logic [2:0] {
        WAIT_HEADER,
        WAIT_BLUE,
        WAIT_GREEN,
        WAIT_RED,
        WAIT_ALPHA
    } byte_phase_e;

    // One decoded pixel as it should leave the m_ channel
    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [23:0] first_index;
        logic [7:0]  run_len;
        logic        past_end;
    } pixel_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;   // [7:0] stream_byte
    logic                   s_tuser;   // [0] image_start
    logic                   m_tvalid;
    logic                   m_tready;
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
    // [55:32] pixel_index, [63:56] repeat_count
    logic [63:0]            m_tdata;
    logic                   m_tuser;   // [0] past_end
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tga_rle_pixel_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Shadow of the config registers, matching their reset values
    logic        alpha_on    = 1'b0;
    logic [23:0] image_size  = 24'hFFFFFF;

    // Decoder state, mirrored from the expected behavior
    byte_phase_e phase       = WAIT_HEADER;
    logic        run_pkt     = 1'b0;
    logic [7:0]  pix_left    = 8'd0;
    logic [7:0]  blue_hold   = 8'd0;
    logic [7:0]  green_hold  = 8'd0;
    logic [7:0]  red_hold    = 8'd0;
    logic [23:0] next_index  = 24'd0;

    pixel_t      pending_pixels[$];
    pixel_t      want;
    int          mismatches  = 0;
    int          idle_cycles = 0;

    // Traffic shaping knobs, flipped by the tests
    bit          tx_steady   = 1'b0;   // sender never idles
    bit          rx_steady   = 1'b0;   // receiver never stalls
    int          rx_hold_req = 0;      // one-shot long hold-off on m_tready

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Mostly short gaps, occasionally a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned exp_v,
                                   input longint unsigned got_v);
        if (mismatches < 50)
            $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $time);
        mismatches++;
    endtask

    // Pixel completes: record expected result and advance the packet state.
    task automatic finish_pixel(input logic [7:0] alpha_byte);
        pixel_t      px;
        logic [7:0]  span;
        logic [24:0] stop;
        span = run_pkt ? pix_left : 8'd1;
        stop = {1'b0, next_index} + {17'd0, span};
        px.red         = red_hold;
        px.green       = green_hold;
        px.blue        = blue_hold;
        px.alpha       = alpha_byte;
        px.first_index = next_index;
        px.run_len     = span;
        px.past_end    = stop > {1'b0, image_size};
        pending_pixels.push_back(px);
        // index saturates instead of wrapping
        next_index = (stop > {1'b0, INDEX_MAX}) ? INDEX_MAX : stop[23:0];
        if (run_pkt) begin
            pix_left = 8'd0;
            phase    = WAIT_HEADER;
        end else begin
            pix_left = pix_left - 8'd1;
            phase    = (pix_left == 8'd0) ? WAIT_HEADER : WAIT_BLUE;
        end
    endtask

    // Expected decoder reaction to one accepted stream byte
    task automatic decode_byte(input logic [7:0] b, input logic first);
        if (first) begin
            phase      = WAIT_HEADER;
            run_pkt    = 1'b0;
            pix_left   = 8'd0;
            next_index = 24'd0;
        end
        case (phase)
            WAIT_BLUE: begin
                blue_hold = b;
                phase     = WAIT_GREEN;
            end
            WAIT_GREEN: begin
                green_hold = b;
                phase      = WAIT_RED;
            end
            WAIT_RED: begin
                red_hold = b;
                // alpha setting is taken here, at the red byte
                if (alpha_on) phase = WAIT_ALPHA;
                else finish_pixel(ALPHA_OPAQUE);
            end
            WAIT_ALPHA: begin
                finish_pixel(b);
            end
            default: begin
                run_pkt  = (b & RUN_FLAG_MASK) != 8'd0;
                pix_left = (b & COUNT_MASK) + 8'd1;
                phase    = WAIT_BLUE;
            end
        endcase
    endtask

    // One s_ transfer. Called right after a rising edge; returns right after the
    // edge that accepted the byte. tvalid stays high when the next byte follows at once.
    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b, first);
    endtask

    // Header plus random pixel bytes for a whole packet
    task automatic send_packet(input logic [7:0] hdr, input logic first, output int nbytes);
        int npix;
        int per_pix;
        npix    = hdr[7] ? 1 : int'(hdr[6:0]) + 1;
        per_pix = alpha_on ? 4 : 3;
        send_byte(hdr, first);
        nbytes = 1;
        for (int p = 0; p < npix; p++) begin
            for (int k = 0; k < per_pix; k++) send_byte(8'($urandom), 1'b0);
            nbytes += per_pix;
        end
    endtask

    // Drop tvalid, wait for every expected pixel, then let the pipeline go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write; the trailing edge keeps cfg_we from toggling twice in a step
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_ALPHA_PRESENT:     alpha_on   = value[0];
            CFG_IMAGE_PIXEL_COUNT: image_size = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Reset defaults: 3-byte pixels, raw then run packet, color extremes
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        settle();
    endtask

    // 4-byte pixels and changes of the alpha setting in the middle of a pixel
    task automatic test_alpha_bytes();
        write_reg(CFG_ALPHA_PRESENT, 24'd1);
        send_byte(8'hFF, 1'b1);    // run of 128
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h00, 1'b0);
        // alpha byte already awaited: it still completes the pixel after clearing the setting
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hBB, 1'b0);
        send_byte(8'hCC, 1'b0);
        settle();
        write_reg(CFG_ALPHA_PRESENT, 24'd0);
        send_byte(8'hFF, 1'b0);
        // setting raised before the red byte: pixel now takes an alpha byte
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        settle();
        write_reg(CFG_ALPHA_PRESENT, 24'd1);
        send_byte(8'h03, 1'b0);
        send_byte(8'h80, 1'b0);
        settle();
    endtask

    // past_end at the image boundary, zero-size image, restart inside a packet
    task automatic test_image_end();
        write_reg(CFG_ALPHA_PRESENT, 24'd0);
        write_reg(CFG_IMAGE_PIXEL_COUNT, 24'd5);
        send_byte(8'h83, 1'b1);    // run of 4, pixels 0..3
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(8'h01, 1'b0);    // two raw pixels: last in image, first past it
        send_byte(8'h40, 1'b0);
        send_byte(8'h50, 1'b0);
        send_byte(8'h60, 1'b0);
        send_byte(8'h70, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h90, 1'b0);
        settle();
        write_reg(CFG_IMAGE_PIXEL_COUNT, 24'd0);
        send_byte(8'h02, 1'b1);    // packet cut short by a new image
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b0);
        send_byte(8'h55, 1'b0);
        settle();
    endtask

    // Receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        int n;
        write_reg(CFG_IMAGE_PIXEL_COUNT, 24'd12);
        tx_steady   = 1'b1;
        rx_hold_req = 300;
        send_packet(8'h13, 1'b1, n);   // 20 raw pixels
        send_packet(8'h9F, 1'b0, n);
        settle();
        tx_steady = 1'b0;
    endtask

    // Random images: mostly well-formed packets, some stray bytes and restarts
    task automatic test_random_images();
        int          sent;
        int          n;
        int          r;
        logic        first;
        logic [7:0]  hdr;
        logic [23:0] size_v;
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            write_reg(CFG_ALPHA_PRESENT, 24'($urandom_range(0, 1)));
            case ($urandom_range(0, 5))
                0: size_v = 24'd1;
                1: size_v = 24'($urandom_range(1, 64));
                2: size_v = 24'($urandom_range(1, 1500));
                3: size_v = 24'd0;
                4: size_v = 24'($urandom);
                default: size_v = INDEX_MAX;
            endcase
            write_reg(CFG_IMAGE_PIXEL_COUNT, size_v);
            // one phase with no idling on either side
            tx_steady = (ph == 2);
            rx_steady = (ph == 2);
            sent  = 0;
            first = 1'b1;
            while (sent < 60) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    send_byte(8'($urandom), 1'($urandom_range(0, 1)));
                    sent++;
                end else begin
                    hdr = 8'($urandom);
                    if ($urandom_range(0, 99) < 90) hdr[6:0] = 7'($urandom_range(0, 7));
                    send_packet(hdr, first || ($urandom_range(0, 99) < 3), n);
                    sent += n;
                    first = 1'b0;
                end
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        settle();
    endtask

    // Receiver readiness: random stalls, plus a one-shot long hold-off on request
    initial begin
        int stall;
        stall = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req > 0) begin
                stall       = rx_hold_req;
                rx_hold_req = 0;
            end else if (stall == 0 && !rx_steady && $urandom_range(0, 99) < 20) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare every m_ transfer with the oldest expected pixel
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected pixel", 0, m_tdata);
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata[7:0] !== want.red)
                    report_mismatch("red", want.red, m_tdata[7:0]);
                if (m_tdata[15:8] !== want.green)
                    report_mismatch("green", want.green, m_tdata[15:8]);
                if (m_tdata[23:16] !== want.blue)
                    report_mismatch("blue", want.blue, m_tdata[23:16]);
                if (m_tdata[31:24] !== want.alpha)
                    report_mismatch("alpha", want.alpha, m_tdata[31:24]);
                if (m_tdata[55:32] !== want.first_index)
                    report_mismatch("pixel_index", want.first_index, m_tdata[55:32]);
                if (m_tdata[63:56] !== want.run_len)
                    report_mismatch("repeat_count", want.run_len, m_tdata[63:56]);
                if (m_tuser !== want.past_end)
                    report_mismatch("past_end", want.past_end, m_tuser);
            end
        end
    end

    // Hang detection: count cycles with no transfer on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        s_tuser   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_ALPHA_PRESENT;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn   <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_alpha_bytes();
        test_image_end();
        test_backpressure();
        test_random_images();

        settle();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
